/* rtl/ptgb_pkg.sv */
// Shared widths, codes, lane control type and the tint blend step for the palette tint unit.
package ptgb_pkg;

    localparam int CHAN_W       = 8;
    localparam int TABLE_SIZE   = 256;
    localparam int GAMMA_ADDR_W = $clog2(TABLE_SIZE);
    localparam int TINT_REGS    = 4;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 32;
    localparam int NUM_TINTS_DEF = 4;

    localparam logic OP_TABLE_WRITE = 1'b0;
    localparam logic OP_COLOR       = 1'b1;

    typedef struct packed {
        logic                    tbl_we;
        logic                    rd_en;
        logic [GAMMA_ADDR_W-1:0] tbl_addr;
        logic [CHAN_W-1:0]       tbl_data;
    } ptgb_ctrl_t;

    // c moves toward d by floor(p * (d - c) / 256)
    function automatic logic [CHAN_W-1:0] blend_step(
        input logic [CHAN_W-1:0] c,
        input logic [CHAN_W-1:0] d,
        input logic [CHAN_W-1:0] p
    );
        logic [CHAN_W-1:0]   diff;
        logic [2*CHAN_W-1:0] prod;
        logic [2*CHAN_W-1:0] rounded;
        logic [CHAN_W-1:0]   result;
        if (d >= c) begin
            diff    = d - c;
            prod    = p * diff;
            rounded = prod;
            result  = c + rounded[2*CHAN_W-1:CHAN_W];
        end else begin
            diff    = c - d;
            prod    = p * diff;
            rounded = prod + {{CHAN_W{1'b0}}, {CHAN_W{1'b1}}};
            result  = c - rounded[2*CHAN_W-1:CHAN_W];
        end
        return result;
    endfunction

endpackage

/* rtl/ptgb_lane.sv */
// One color channel lane: pipelined tint blend stages and its own gamma table copy.
module ptgb_lane #(
    parameter int NUM_TINTS = ptgb_pkg::NUM_TINTS_DEF
) (
    input  logic                        aclk,
    input  logic [ptgb_pkg::CHAN_W-1:0] base_in,
    input  logic [ptgb_pkg::CHAN_W-1:0] dest [NUM_TINTS],
    input  logic [ptgb_pkg::CHAN_W-1:0] pct  [NUM_TINTS],
    input  logic [NUM_TINTS-1:0]        stage_en,
    input  ptgb_pkg::ptgb_ctrl_t        ctrl,
    output logic [ptgb_pkg::CHAN_W-1:0] gamma_out
);
    import ptgb_pkg::*;

    localparam int LAST = NUM_TINTS - 1;

    logic [CHAN_W-1:0] chan_reg  [NUM_TINTS];
    logic [CHAN_W-1:0] chan_next [NUM_TINTS];
    logic [CHAN_W-1:0] gamma_mem [TABLE_SIZE];
    logic [CHAN_W-1:0] gamma_reg;

    for (genvar k = 0; k < NUM_TINTS; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign chan_next[k] = blend_step(base_in, dest[k], pct[k]);
        end else begin : g_rest
            assign chan_next[k] = blend_step(chan_reg[k-1], dest[k], pct[k]);
        end

        always_ff @(posedge aclk) begin
            if (stage_en[k]) begin
                chan_reg[k] <= chan_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.tbl_we) begin
            gamma_mem[ctrl.tbl_addr] <= ctrl.tbl_data;
        end
        if (ctrl.rd_en) begin
            gamma_reg <= gamma_mem[chan_reg[LAST]];
        end
    end

    assign gamma_out = gamma_reg;

endmodule

/* rtl/ptgb_merge.sv */
// Output stage: joins the three lane results with the palette index and holds the transaction.
module ptgb_merge (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  logic [ptgb_pkg::CHAN_W-1:0]    index_in,
    input  logic [ptgb_pkg::CHAN_W-1:0]    red_in,
    input  logic [ptgb_pkg::CHAN_W-1:0]    green_in,
    input  logic [ptgb_pkg::CHAN_W-1:0]    blue_in,
    output logic                           out_ready,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // fields from bit 0: out_index, out_red, out_green, out_blue
    output logic [ptgb_pkg::M_TDATA_W-1:0] m_tdata
);
    import ptgb_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [CHAN_W-1:0] index_reg;

    assign out_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            index_reg <= index_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {blue_in, green_in, red_in, index_reg};

endmodule

/* rtl/palette_tint_gamma_blend_unit.sv */
// An accepted color transaction runs one blend stage per tint, then one gamma read stage.
// Throughput: one transaction per cycle while the output is not stalled.
// Table writes ride the same pipeline and update all three gamma copies at the read stage.
// Reset clears the valid bits and the tint registers; the gamma tables are not cleared.
// Stalls propagate back combinationally, so bubbles collapse while a result waits.
module palette_tint_gamma_blend_unit #(
    parameter int NUM_TINTS = ptgb_pkg::NUM_TINTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ptgb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ptgb_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // fields from bit 0: entry_index, table_value, base_red, base_green, base_blue
    input  logic [ptgb_pkg::S_TDATA_W-1:0]  s_tdata,
    // fields from bit 0: operation
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // fields from bit 0: out_index, out_red, out_green, out_blue
    output logic [ptgb_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ptgb_pkg::*;

    localparam int LAST = NUM_TINTS - 1;

    logic [CFG_DATA_W-1:0] tint_reg [TINT_REGS];

    logic [CHAN_W-1:0] pct    [NUM_TINTS];
    logic [CHAN_W-1:0] dest_r [NUM_TINTS];
    logic [CHAN_W-1:0] dest_g [NUM_TINTS];
    logic [CHAN_W-1:0] dest_b [NUM_TINTS];

    logic [NUM_TINTS-1:0] vld_reg;
    logic [NUM_TINTS-1:0] vld_next;
    logic [NUM_TINTS-1:0] op_reg;
    logic [CHAN_W-1:0]    idx_reg [NUM_TINTS];
    logic [CHAN_W-1:0]    tv_reg  [NUM_TINTS];
    logic [NUM_TINTS-1:0] free;

    logic              out_ready;
    ptgb_ctrl_t        ctrl;
    logic [CHAN_W-1:0] gamma_r;
    logic [CHAN_W-1:0] gamma_g;
    logic [CHAN_W-1:0] gamma_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TINT_REGS; i++) begin
                tint_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            tint_reg[cfg_addr] <= cfg_wr_data;
        end
    end

    for (genvar k = 0; k < NUM_TINTS; k++) begin : g_tint
        assign pct[k]    = tint_reg[k][31:24];
        assign dest_r[k] = tint_reg[k][23:16];
        assign dest_g[k] = tint_reg[k][15:8];
        assign dest_b[k] = tint_reg[k][7:0];

        if (k == LAST) begin : g_last
            assign free[k] = !vld_reg[k] || (op_reg[k] == OP_TABLE_WRITE) || out_ready;
        end else begin : g_mid
            assign free[k] = !vld_reg[k] || free[k+1];
        end

        if (k == 0) begin : g_first
            assign vld_next[k] = free[k] ? s_tvalid : vld_reg[k];
            always_ff @(posedge aclk) begin
                if (free[k]) begin
                    op_reg[k]  <= s_tuser;
                    idx_reg[k] <= s_tdata[7:0];
                    tv_reg[k]  <= s_tdata[15:8];
                end
            end
        end else begin : g_rest
            assign vld_next[k] = free[k] ? vld_reg[k-1] : vld_reg[k];
            always_ff @(posedge aclk) begin
                if (free[k]) begin
                    op_reg[k]  <= op_reg[k-1];
                    idx_reg[k] <= idx_reg[k-1];
                    tv_reg[k]  <= tv_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = free[0];

    always_comb begin
        ctrl.tbl_we   = vld_reg[LAST] && (op_reg[LAST] == OP_TABLE_WRITE);
        ctrl.rd_en    = vld_reg[LAST] && (op_reg[LAST] == OP_COLOR) && out_ready;
        ctrl.tbl_addr = idx_reg[LAST];
        ctrl.tbl_data = tv_reg[LAST];
    end

    ptgb_lane #(.NUM_TINTS(NUM_TINTS)) u_lane_red (
        .aclk      (aclk),
        .base_in   (s_tdata[23:16]),
        .dest      (dest_r),
        .pct       (pct),
        .stage_en  (free),
        .ctrl      (ctrl),
        .gamma_out (gamma_r)
    );

    ptgb_lane #(.NUM_TINTS(NUM_TINTS)) u_lane_green (
        .aclk      (aclk),
        .base_in   (s_tdata[31:24]),
        .dest      (dest_g),
        .pct       (pct),
        .stage_en  (free),
        .ctrl      (ctrl),
        .gamma_out (gamma_g)
    );

    ptgb_lane #(.NUM_TINTS(NUM_TINTS)) u_lane_blue (
        .aclk      (aclk),
        .base_in   (s_tdata[39:32]),
        .dest      (dest_b),
        .pct       (pct),
        .stage_en  (free),
        .ctrl      (ctrl),
        .gamma_out (gamma_b)
    );

    ptgb_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (ctrl.rd_en),
        .index_in  (idx_reg[LAST]),
        .red_in    (gamma_r),
        .green_in  (gamma_g),
        .blue_in   (gamma_b),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transaction did not enter the first stage");

    a_read_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.rd_en |=> m_tvalid)
        else $error("gamma read did not produce an output transaction");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[LAST] && (op_reg[LAST] == OP_COLOR) && !out_ready)
        |=> (vld_reg[LAST] && $stable(idx_reg[LAST])))
        else $error("stalled color transaction left the last stage");
`endif

endmodule
